// ===== hw/rtl/svdw_pkg.sv =====
// switched 12-6 pair accumulator: shared types, codes, microprogram and fixed-point helpers
// no dependencies; every other file uses this package by scoped names
`default_nettype none

package svdw_pkg;

   localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
   localparam logic [63:0] MAG_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

   // request actions
   localparam logic [1:0] ACT_PAIR      = 2'd0;
   localparam logic [1:0] ACT_LOAD_DIST = 2'd1;
   localparam logic [1:0] ACT_LOAD_EN   = 2'd2;
   localparam logic [1:0] ACT_LOAD_FRC  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SWITCH_START = 2'd0;
   localparam logic [1:0] CSR_CUT_DISTANCE = 2'd1;
   localparam logic [1:0] CSR_BOX_LENGTH   = 2'd2;

   // micro-op codes
   localparam logic [2:0] OP_MUL  = 3'd0;
   localparam logic [2:0] OP_DIV  = 3'd1;
   localparam logic [2:0] OP_ADD  = 3'd2;
   localparam logic [2:0] OP_SUB  = 3'd3;
   localparam logic [2:0] OP_ACC  = 3'd4;   // add, subtract on exclusion
   localparam logic [2:0] OP_NACC = 3'd5;   // subtract, add on exclusion

   // fixed operand sources; bit 5 set selects a temporary
   localparam logic [5:0] SRC_R2   = 6'd0;
   localparam logic [5:0] SRC_C2   = 6'd1;
   localparam logic [5:0] SRC_O2   = 6'd2;
   localparam logic [5:0] SRC_RS   = 6'd3;
   localparam logic [5:0] SRC_GS   = 6'd4;
   localparam logic [5:0] SRC_FGS  = 6'd5;
   localparam logic [5:0] SRC_DX0  = 6'd6;
   localparam logic [5:0] SRC_DX1  = 6'd7;
   localparam logic [5:0] SRC_DX2  = 6'd8;
   localparam logic [5:0] SRC_ONE  = 6'd9;
   localparam logic [5:0] SRC_K2   = 6'd10;
   localparam logic [5:0] SRC_K3   = 6'd11;
   localparam logic [5:0] SRC_K6   = 6'd12;
   localparam logic [5:0] SRC_K12  = 6'd13;
   localparam logic [5:0] SRC_ZERO = 6'd14;
   localparam logic [5:0] SRC_ESUM = 6'd15;
   localparam logic [5:0] SRC_FX   = 6'd16;
   localparam logic [5:0] SRC_FY   = 6'd17;
   localparam logic [5:0] SRC_FZ   = 6'd18;

   // destinations of accumulators; below these a temporary
   localparam logic [4:0] DST_ESUM = 5'd16;
   localparam logic [4:0] DST_FX   = 5'd17;
   localparam logic [4:0] DST_FY   = 5'd18;
   localparam logic [4:0] DST_FZ   = 5'd19;

   // temporaries
   localparam logic [3:0] T_INV2  = 4'd0;
   localparam logic [3:0] T_INV6  = 4'd1;
   localparam logic [3:0] T_EM1   = 4'd2;
   localparam logic [3:0] T_BASE  = 4'd3;
   localparam logic [3:0] T_TMP   = 4'd4;
   localparam logic [3:0] T_DTMP  = 4'd5;
   localparam logic [3:0] T_DIFFC = 4'd6;
   localparam logic [3:0] T_D     = 4'd7;
   localparam logic [3:0] T_TMP1  = 4'd8;
   localparam logic [3:0] T_POLY  = 4'd9;
   localparam logic [3:0] T_TMP2  = 4'd10;
   localparam logic [3:0] T_T1    = 4'd11;
   localparam logic [3:0] T_INNER = 4'd12;
   localparam logic [3:0] T_T2    = 4'd13;
   localparam logic [3:0] T_S0    = 4'd14;
   localparam logic [3:0] T_S1    = 4'd15;

   // program counter landmarks
   localparam logic [5:0] PC_BRANCH    = 6'd5;
   localparam logic [5:0] PC_INNER     = 6'd6;
   localparam logic [5:0] PC_INNER_END = 6'd10;
   localparam logic [5:0] PC_SWITCH    = 6'd11;
   localparam logic [5:0] PC_TAIL      = 6'd34;
   localparam logic [5:0] PC_END       = 6'd42;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] a;
      logic [5:0] b;
      logic [4:0] dst;
   } uop_type;

   typedef struct packed {
      logic       en;
      logic [1:0] sel;
   } tbl_wr_type;

   function automatic logic [5:0] tsrc(input logic [3:0] t);
      return {2'b10, t};
   endfunction

   function automatic logic [4:0] tdst(input logic [3:0] t);
      return {1'b0, t};
   endfunction

   function automatic uop_type mk(input logic [2:0] op, input logic [5:0] a,
                                  input logic [5:0] b, input logic [4:0] d);
      uop_type u;
      u.op  = op;
      u.a   = a;
      u.b   = b;
      u.dst = d;
      return u;
   endfunction

   function automatic uop_type uop_rom(input logic [5:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_MUL, SRC_R2, SRC_RS, tdst(T_S0));
         6'd1:  u = mk(OP_DIV, SRC_ONE, tsrc(T_S0), tdst(T_INV2));
         6'd2:  u = mk(OP_MUL, tsrc(T_INV2), tsrc(T_INV2), tdst(T_S0));
         6'd3:  u = mk(OP_MUL, tsrc(T_S0), tsrc(T_INV2), tdst(T_INV6));
         6'd4:  u = mk(OP_SUB, tsrc(T_INV6), SRC_ONE, tdst(T_EM1));
         6'd5:  u = mk(OP_MUL, tsrc(T_INV6), tsrc(T_EM1), tdst(T_BASE));
         // inside cuton
         6'd6:  u = mk(OP_ADD, tsrc(T_BASE), SRC_ZERO, tdst(T_TMP));
         6'd7:  u = mk(OP_MUL, tsrc(T_INV2), tsrc(T_INV6), tdst(T_S0));
         6'd8:  u = mk(OP_MUL, tsrc(T_INV6), SRC_K2, tdst(T_S1));
         6'd9:  u = mk(OP_SUB, tsrc(T_S1), SRC_ONE, tdst(T_S1));
         6'd10: u = mk(OP_MUL, tsrc(T_S0), tsrc(T_S1), tdst(T_DTMP));
         // switching region
         6'd11: u = mk(OP_SUB, SRC_C2, SRC_R2, tdst(T_DIFFC));
         6'd12: u = mk(OP_SUB, SRC_C2, SRC_O2, tdst(T_D));
         6'd13: u = mk(OP_MUL, tsrc(T_D), tsrc(T_D), tdst(T_S0));
         6'd14: u = mk(OP_MUL, tsrc(T_S0), tsrc(T_D), tdst(T_S0));
         6'd15: u = mk(OP_DIV, tsrc(T_DIFFC), tsrc(T_S0), tdst(T_TMP1));
         6'd16: u = mk(OP_MUL, SRC_O2, SRC_K3, tdst(T_S0));
         6'd17: u = mk(OP_SUB, SRC_C2, tsrc(T_S0), tdst(T_S0));
         6'd18: u = mk(OP_MUL, SRC_R2, SRC_K2, tdst(T_S1));
         6'd19: u = mk(OP_ADD, tsrc(T_S0), tsrc(T_S1), tdst(T_POLY));
         6'd20: u = mk(OP_MUL, tsrc(T_TMP1), tsrc(T_DIFFC), tdst(T_S0));
         6'd21: u = mk(OP_MUL, tsrc(T_S0), tsrc(T_POLY), tdst(T_TMP2));
         6'd22: u = mk(OP_MUL, tsrc(T_BASE), SRC_K12, tdst(T_S0));
         6'd23: u = mk(OP_SUB, SRC_O2, SRC_R2, tdst(T_S1));
         6'd24: u = mk(OP_MUL, tsrc(T_S0), tsrc(T_S1), tdst(T_S0));
         6'd25: u = mk(OP_MUL, tsrc(T_S0), tsrc(T_TMP1), tdst(T_T1));
         6'd26: u = mk(OP_MUL, tsrc(T_EM1), tsrc(T_TMP2), tdst(T_S0));
         6'd27: u = mk(OP_ADD, tsrc(T_INV6), tsrc(T_S0), tdst(T_INNER));
         6'd28: u = mk(OP_MUL, tsrc(T_INV6), SRC_K6, tdst(T_S0));
         6'd29: u = mk(OP_MUL, tsrc(T_S0), tsrc(T_INNER), tdst(T_S0));
         6'd30: u = mk(OP_MUL, tsrc(T_S0), tsrc(T_TMP2), tdst(T_S0));
         6'd31: u = mk(OP_DIV, tsrc(T_S0), SRC_R2, tdst(T_T2));
         6'd32: u = mk(OP_MUL, tsrc(T_BASE), tsrc(T_TMP2), tdst(T_TMP));
         6'd33: u = mk(OP_SUB, tsrc(T_T1), tsrc(T_T2), tdst(T_DTMP));
         // common tail: scale and accumulate
         6'd34: u = mk(OP_MUL, tsrc(T_DTMP), SRC_FGS, tdst(T_DTMP));
         6'd35: u = mk(OP_MUL, SRC_GS, tsrc(T_TMP), tdst(T_S0));
         6'd36: u = mk(OP_ACC, SRC_ESUM, tsrc(T_S0), DST_ESUM);
         6'd37: u = mk(OP_MUL, SRC_DX0, tsrc(T_DTMP), tdst(T_S1));
         6'd38: u = mk(OP_NACC, SRC_FX, tsrc(T_S1), DST_FX);
         6'd39: u = mk(OP_MUL, SRC_DX1, tsrc(T_DTMP), tdst(T_S1));
         6'd40: u = mk(OP_NACC, SRC_FY, tsrc(T_S1), DST_FY);
         6'd41: u = mk(OP_MUL, SRC_DX2, tsrc(T_DTMP), tdst(T_S1));
         6'd42: u = mk(OP_NACC, SRC_FZ, tsrc(T_S1), DST_FZ);
         default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, tdst(T_S1));
      endcase
      return u;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : MAG_CAP;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] qsub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : MAG_CAP;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] to_signed_q(input logic [63:0] u);
      return u[63] ? MAG_CAP : u;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/svdw_mul.sv =====
// saturating signed Q32.32 multiplier, one 32x32 partial product per cycle
// uses svdw_pkg for constants and the magnitude helper
`default_nettype none

module svdw_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] a,
   input  wire logic signed [63:0] b,
   output logic                    done,
   output logic signed [63:0]      y
);

   logic         busy_ff, busy_in;
   logic         fin_ff, fin_in;
   logic         done_ff, done_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [63:0]  ma_ff, mb_ff;
   logic         neg_ff;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  y_ff, y_in;
   logic [31:0]  ah, bh;
   logic [63:0]  pp;
   logic [6:0]   shamt;
   logic [63:0]  m;

   always_comb begin
      ah    = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      bh    = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      pp    = 64'(ah) * 64'(bh);
      shamt = 7'(32 * (32'(cnt_ff[1]) + 32'(cnt_ff[0])));
      acc_in = acc_ff;
      if (start) begin
         acc_in = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + (128'(pp) << shamt);
      end
      // the result is the product shifted down 32, capped at the largest magnitude
      m    = (|acc_ff[127:95]) ? svdw_pkg::MAG_CAP : acc_ff[95:32];
      y_in = neg_ff ? 64'(-$signed(m)) : m;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= svdw_pkg::mag64(a);
         mb_ff  <= svdw_pkg::mag64(b);
         neg_ff <= a[63] ^ b[63];
      end
      acc_ff <= acc_in;
      if (fin_ff) begin
         y_ff <= y_in;
      end
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/svdw_div.sv =====
// saturating signed Q32.32 divider, restoring, one quotient bit per cycle
// uses svdw_pkg for constants and the magnitude helper
`default_nettype none

module svdw_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] a,
   input  wire logic signed [63:0] b,
   output logic                    done,
   output logic signed [63:0]      y
);

   logic         busy_ff, busy_in;
   logic         fin_ff, fin_in;
   logic         done_ff;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  mb_ff;
   logic [63:0]  rem_ff, rem_in;
   logic [95:0]  qd_ff, qd_in;
   logic         neg_ff, bz_ff, az_ff;
   logic [64:0]  rem_sh;
   logic         ge;
   logic [63:0]  m;
   logic [63:0]  y_ff, y_in;

   always_comb begin
      rem_sh = {rem_ff, qd_ff[95]};
      ge     = rem_sh >= {1'b0, mb_ff};
      rem_in = ge ? 64'(rem_sh - {1'b0, mb_ff}) : rem_sh[63:0];
      qd_in  = {qd_ff[94:0], ge};
      if (bz_ff) begin
         // zero divisor: largest magnitude with the dividend's sign, zero for zero
         m = az_ff ? 64'd0 : svdw_pkg::MAG_CAP;
      end else begin
         m = (|qd_ff[95:63]) ? svdw_pkg::MAG_CAP : qd_ff[63:0];
      end
      y_in = neg_ff ? 64'(-$signed(m)) : m;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      fin_in  = 1'b0;
      if (start) begin
         busy_in = (b != '0);
         fin_in  = (b == '0);
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd95) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mb_ff  <= svdw_pkg::mag64(b);
         qd_ff  <= {svdw_pkg::mag64(a), 32'h0};
         rem_ff <= '0;
         neg_ff <= a[63] ^ b[63];
         bz_ff  <= (b == '0);
         az_ff  <= (a == '0);
      end else if (busy_ff) begin
         qd_ff  <= qd_in;
         rem_ff <= rem_in;
      end
      if (fin_ff) begin
         y_ff <= y_in;
      end
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/svdw_tables.sv =====
// per-type-pair scale memories: distance, energy and force words
// uses svdw_pkg for the write control struct and action codes
`default_nettype none

module svdw_tables #(
   parameter int DEPTH = 256,
   parameter int IDX_W = 8
) (
   input  wire logic                   clock,
   input  wire svdw_pkg::tbl_wr_type   wr,
   input  wire logic [IDX_W-1:0]       wr_idx,
   input  wire logic [31:0]            wr_data,
   input  wire logic [IDX_W-1:0]       rd_idx,
   output logic [31:0]                 rd_dist,
   output logic [31:0]                 rd_energy,
   output logic [31:0]                 rd_force
);

   logic [31:0] dist_mem   [DEPTH];
   logic [31:0] energy_mem [DEPTH];
   logic [31:0] force_mem  [DEPTH];
   logic [31:0] rd_dist_ff, rd_energy_ff, rd_force_ff;

   always_ff @(posedge clock) begin
      if (wr.en && wr.sel == svdw_pkg::ACT_LOAD_DIST) begin
         dist_mem[wr_idx] <= wr_data;
      end
      rd_dist_ff <= dist_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.sel == svdw_pkg::ACT_LOAD_EN) begin
         energy_mem[wr_idx] <= wr_data;
      end
      rd_energy_ff <= energy_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.sel == svdw_pkg::ACT_LOAD_FRC) begin
         force_mem[wr_idx] <= wr_data;
      end
      rd_force_ff <= force_mem[rd_idx];
   end

   assign rd_dist   = rd_dist_ff;
   assign rd_energy = rd_energy_ff;
   assign rd_force  = rd_force_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/switched_vdw_pair_accumulator.sv =====
// a table load is written when it is accepted; a pair is wrapped into the box and squared,
// then runs one micro-op after another: multiplies, adds, subtracts and divides. a pair inside
// cuton runs the inner branch, a switched pair the switching branch, a skipped pair no micro-ops.
// one request at a time; a pair marked last waits in its finish state while the previous
// result is still stalled. synchronous active-high reset clears control, configuration and
// the sums; scale memories undefined
`default_nettype none

module switched_vdw_pair_accumulator #(
   parameter int NUM_TYPES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic [3:0]         req_type_i,
   input  wire logic [3:0]         req_type_j,
   input  wire logic signed [31:0] req_xi,
   input  wire logic signed [31:0] req_yi,
   input  wire logic signed [31:0] req_zi,
   input  wire logic signed [31:0] req_xj,
   input  wire logic signed [31:0] req_yj,
   input  wire logic signed [31:0] req_zj,
   input  wire logic signed [31:0] req_table_value,
   input  wire logic               req_last_partner,
   input  wire logic               req_exclusion,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [63:0]      rsp_energy,
   output logic signed [63:0]      rsp_force_x,
   output logic signed [63:0]      rsp_force_y,
   output logic signed [63:0]      rsp_force_z,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam int DEPTH  = NUM_TYPES * NUM_TYPES;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRAP1 = 4'd1;
   localparam logic [3:0] ST_WRAP2 = 4'd2;
   localparam logic [3:0] ST_MAG   = 4'd3;
   localparam logic [3:0] ST_SQ    = 4'd4;
   localparam logic [3:0] ST_CHECK = 4'd5;
   localparam logic [3:0] ST_READ  = 4'd6;
   localparam logic [3:0] ST_ISSUE = 4'd7;
   localparam logic [3:0] ST_WAIT  = 4'd8;
   localparam logic [3:0] ST_WB    = 4'd9;
   localparam logic [3:0] ST_FIN   = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic        req_accept;

   // configuration
   logic [31:0] start_ff, cut_ff, box_ff;

   // request capture
   logic [IDX_W-1:0]   idx_in, idx_ff;
   logic               last_ff, excl_ff;
   logic signed [34:0] d_ff [3];
   logic signed [34:0] d_in [3];
   logic [33:0]        m_ff [3];
   logic               far_ff;

   // squaring
   logic [2:0]  sq_cnt_ff;
   logic [31:0] sq_op;
   logic [63:0] sq_prod;
   logic [64:0] r2_sum;
   logic [63:0] r2_ff, c2_ff, o2_ff;
   logic        sw_ff;

   // micro-program
   logic [5:0]         pc_ff, pc_in;
   svdw_pkg::uop_type  uop;
   logic signed [63:0] rf [16];
   logic signed [63:0] rf_a_ff, rf_b_ff;
   logic signed [63:0] opa, opb, alu_res;
   logic signed [63:0] res_ff;
   logic signed [63:0] r2s, c2s, o2s, rs_q, gs_q, fgs_q;
   logic               mul_start, div_start, mul_done, div_done;
   logic signed [63:0] mul_y, div_y;

   // sums and result
   logic signed [63:0] esum_ff, fx_ff, fy_ff, fz_ff;
   logic               rsp_valid_ff;
   logic signed [63:0] out_e_ff, out_x_ff, out_y_ff, out_z_ff;
   logic               rsp_load;

   // tables
   svdw_pkg::tbl_wr_type tbl_wr;
   logic [31:0]          tbl_dist, tbl_energy, tbl_force;

   function automatic logic [TYPE_W-1:0] type_mod(input logic [3:0] t);
      logic [TYPE_W-1:0] r;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         if (t == 4'(k)) r = TYPE_W'(k % NUM_TYPES);
      end
      return r;
   endfunction

   function automatic logic signed [63:0] src_val(input logic [5:0] s,
                                                 input logic signed [63:0] rfd);
      logic signed [63:0] v;
      if (s[5]) begin
         v = rfd;
      end else begin
         case (s)
            svdw_pkg::SRC_R2:   v = r2s;
            svdw_pkg::SRC_C2:   v = c2s;
            svdw_pkg::SRC_O2:   v = o2s;
            svdw_pkg::SRC_RS:   v = rs_q;
            svdw_pkg::SRC_GS:   v = gs_q;
            svdw_pkg::SRC_FGS:  v = fgs_q;
            svdw_pkg::SRC_DX0:  v = {{13{d_ff[0][34]}}, d_ff[0], 16'h0};
            svdw_pkg::SRC_DX1:  v = {{13{d_ff[1][34]}}, d_ff[1], 16'h0};
            svdw_pkg::SRC_DX2:  v = {{13{d_ff[2][34]}}, d_ff[2], 16'h0};
            svdw_pkg::SRC_ONE:  v = svdw_pkg::Q_ONE;
            svdw_pkg::SRC_K2:   v = 64'(2) << 32;
            svdw_pkg::SRC_K3:   v = 64'(3) << 32;
            svdw_pkg::SRC_K6:   v = 64'(6) << 32;
            svdw_pkg::SRC_K12:  v = 64'(12) << 32;
            svdw_pkg::SRC_ZERO: v = '0;
            svdw_pkg::SRC_ESUM: v = esum_ff;
            svdw_pkg::SRC_FX:   v = fx_ff;
            svdw_pkg::SRC_FY:   v = fy_ff;
            svdw_pkg::SRC_FZ:   v = fz_ff;
            default:            v = '0;
         endcase
      end
      return v;
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign idx_in = IDX_W'(int'(type_mod(req_type_i)) * NUM_TYPES + int'(type_mod(req_type_j)));

   always_comb begin
      tbl_wr.en  = req_accept && (req_action != svdw_pkg::ACT_PAIR);
      tbl_wr.sel = req_action;
   end

   svdw_tables #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_tables (
      .clock     (clock),
      .wr        (tbl_wr),
      .wr_idx    (idx_in),
      .wr_data   (req_table_value),
      .rd_idx    (idx_ff),
      .rd_dist   (tbl_dist),
      .rd_energy (tbl_energy),
      .rd_force  (tbl_force)
   );

   always_comb begin
      r2s   = svdw_pkg::to_signed_q(r2_ff);
      c2s   = svdw_pkg::to_signed_q(c2_ff);
      o2s   = svdw_pkg::to_signed_q(o2_ff);
      rs_q  = {{16{tbl_dist[31]}}, tbl_dist, 16'h0};
      gs_q  = {{16{tbl_energy[31]}}, tbl_energy, 16'h0};
      fgs_q = {{16{tbl_force[31]}}, tbl_force, 16'h0};
   end

   // wrap once into the box, each axis on its own
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = d_ff[k];
         if (state_ff == ST_WRAP1) begin
            if ($signed({d_ff[k], 1'b0}) < -$signed({4'b0, box_ff})) begin
               d_in[k] = d_ff[k] + $signed({3'b0, box_ff});
            end
         end else if (state_ff == ST_WRAP2) begin
            if ($signed({d_ff[k], 1'b0}) > $signed({4'b0, box_ff})) begin
               d_in[k] = d_ff[k] - $signed({3'b0, box_ff});
            end
         end
      end
   end

   always_comb begin
      case (sq_cnt_ff)
         3'd0:    sq_op = m_ff[0][31:0];
         3'd1:    sq_op = m_ff[1][31:0];
         3'd2:    sq_op = m_ff[2][31:0];
         3'd3:    sq_op = cut_ff;
         default: sq_op = start_ff;
      endcase
      sq_prod = 64'(sq_op) * 64'(sq_op);
      r2_sum  = {1'b0, r2_ff} + {1'b0, sq_prod};
   end

   assign uop = svdw_pkg::uop_rom(pc_ff);

   always_comb begin
      opa = src_val(uop.a, rf_a_ff);
      opb = src_val(uop.b, rf_b_ff);
      case (uop.op)
         svdw_pkg::OP_ADD:  alu_res = svdw_pkg::qadd(opa, opb);
         svdw_pkg::OP_SUB:  alu_res = svdw_pkg::qsub(opa, opb);
         svdw_pkg::OP_ACC:  alu_res = excl_ff ? svdw_pkg::qsub(opa, opb)
                                              : svdw_pkg::qadd(opa, opb);
         svdw_pkg::OP_NACC: alu_res = excl_ff ? svdw_pkg::qadd(opa, opb)
                                              : svdw_pkg::qsub(opa, opb);
         default:           alu_res = svdw_pkg::qadd(opa, opb);
      endcase
   end

   assign mul_start = (state_ff == ST_ISSUE) && (uop.op == svdw_pkg::OP_MUL);
   assign div_start = (state_ff == ST_ISSUE) && (uop.op == svdw_pkg::OP_DIV);

   svdw_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (opa),
      .b     (opb),
      .done  (mul_done),
      .y     (mul_y)
   );

   svdw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .a     (opa),
      .b     (opb),
      .done  (div_done),
      .y     (div_y)
   );

   assign rsp_load = (state_ff == ST_FIN) && last_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      pc_in = pc_ff + 6'd1;
      if (pc_ff == svdw_pkg::PC_BRANCH) begin
         pc_in = sw_ff ? svdw_pkg::PC_SWITCH : svdw_pkg::PC_INNER;
      end else if (pc_ff == svdw_pkg::PC_INNER_END) begin
         pc_in = svdw_pkg::PC_TAIL;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_action == svdw_pkg::ACT_PAIR) state_in = ST_WRAP1;
         end
         ST_WRAP1: state_in = ST_WRAP2;
         ST_WRAP2: state_in = ST_MAG;
         ST_MAG:   state_in = ST_SQ;
         ST_SQ: begin
            if (sq_cnt_ff == 3'd4) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!far_ff && r2_ff != '0 && r2_ff != '1 && r2_ff < c2_ff) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_READ: state_in = ST_ISSUE;
         ST_ISSUE: begin
            if (uop.op == svdw_pkg::OP_MUL || uop.op == svdw_pkg::OP_DIV) begin
               state_in = ST_WAIT;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_WAIT: begin
            if (mul_done || div_done) state_in = ST_WB;
         end
         ST_WB: begin
            state_in = (pc_ff == svdw_pkg::PC_END) ? ST_FIN : ST_READ;
         end
         ST_FIN: begin
            if (!last_ff || rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         cut_ff       <= '0;
         box_ff       <= '0;
         esum_ff      <= '0;
         fx_ff        <= '0;
         fy_ff        <= '0;
         fz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         sq_cnt_ff    <= '0;
         pc_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               svdw_pkg::CSR_SWITCH_START: start_ff <= csr_wdata;
               svdw_pkg::CSR_CUT_DISTANCE: cut_ff   <= csr_wdata;
               svdw_pkg::CSR_BOX_LENGTH:   box_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_MAG) begin
            sq_cnt_ff <= '0;
         end else if (state_ff == ST_SQ) begin
            sq_cnt_ff <= sq_cnt_ff + 3'd1;
         end
         if (state_ff == ST_CHECK) begin
            pc_ff <= '0;
         end else if (state_ff == ST_WB) begin
            pc_ff <= pc_in;
         end
         if (state_ff == ST_WB && uop.dst[4]) begin
            case (uop.dst)
               svdw_pkg::DST_ESUM: esum_ff <= res_ff;
               svdw_pkg::DST_FX:   fx_ff   <= res_ff;
               svdw_pkg::DST_FY:   fy_ff   <= res_ff;
               svdw_pkg::DST_FZ:   fz_ff   <= res_ff;
               default: ;
            endcase
         end
         if (rsp_load) begin
            esum_ff      <= '0;
            fx_ff        <= '0;
            fy_ff        <= '0;
            fz_ff        <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_ff  <= idx_in;
         last_ff <= req_last_partner;
         excl_ff <= req_exclusion;
         d_ff[0] <= 35'(req_xi) - 35'(req_xj);
         d_ff[1] <= 35'(req_yi) - 35'(req_yj);
         d_ff[2] <= 35'(req_zi) - 35'(req_zj);
      end else begin
         for (int k = 0; k < 3; k++) d_ff[k] <= d_in[k];
      end
      if (state_ff == ST_MAG) begin
         for (int k = 0; k < 3; k++) begin
            m_ff[k] <= 34'(d_ff[k][34] ? -d_ff[k] : d_ff[k]);
         end
         r2_ff <= '0;
      end
      if (state_ff == ST_SQ) begin
         far_ff <= (|m_ff[0][33:32]) || (|m_ff[1][33:32]) || (|m_ff[2][33:32]);
         case (sq_cnt_ff)
            3'd3:    c2_ff <= sq_prod;
            3'd4:    o2_ff <= sq_prod;
            default: r2_ff <= r2_sum[64] ? '1 : r2_sum[63:0];
         endcase
      end
      if (state_ff == ST_CHECK) begin
         sw_ff <= o2_ff < r2_ff;
      end
      if (state_ff == ST_READ) begin
         rf_a_ff <= rf[uop.a[3:0]];
         rf_b_ff <= rf[uop.b[3:0]];
      end
      if (state_ff == ST_ISSUE) begin
         res_ff <= alu_res;
      end else if (state_ff == ST_WAIT) begin
         if (mul_done) res_ff <= mul_y;
         else if (div_done) res_ff <= div_y;
      end
      if (state_ff == ST_WB && !uop.dst[4]) begin
         rf[uop.dst[3:0]] <= res_ff;
      end
      if (rsp_load) begin
         out_e_ff <= esum_ff;
         out_x_ff <= fx_ff;
         out_y_ff <= fy_ff;
         out_z_ff <= fz_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_energy  = out_e_ff;
   assign rsp_force_x = out_x_ff;
   assign rsp_force_y = out_y_ff;
   assign rsp_force_z = out_z_ff;

   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_WAIT)
      else $error("multiplier finished outside wait");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_WAIT)
      else $error("divider finished outside wait");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result raised outside finish");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (esum_ff == '0 && fx_ff == '0 && fy_ff == '0 && fz_ff == '0))
      else $error("sums not cleared on result");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> pc_ff <= svdw_pkg::PC_END)
      else $error("micro-program counter out of range");

endmodule

`default_nettype wire

// ===== tb/switched_vdw_pair_accumulator_tb.sv =====
// testbench for the switched 12-6 pair accumulator: directed table, then random owner groups
// checked against an in-bench fixed-point predictor; depends on svdw_pkg and the block only
`timescale 1ns / 1ps

module switched_vdw_pair_accumulator_tb;

   localparam logic signed [63:0] Q1     = 64'sh0000_0001_0000_0000;
   localparam logic [63:0]        SMAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]        SMIN   = 64'h8000_0000_0000_0000;
   localparam int                 LIMIT  = 5_000_000;
   localparam int                 SETTLE = 600;

   typedef struct {
      logic [1:0]         act;
      logic [3:0]         ti, tj;
      logic signed [31:0] xi, yi, zi, xj, yj, zj, tv;
      logic               last, excl;
   } pair_req_type;

   typedef struct {
      logic signed [63:0] e, fx, fy, fz;
   } atom_sums_type;

   typedef struct {
      bit           is_cfg;
      logic [31:0]  o, c, b;
      pair_req_type r;
      bit           lit;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = '0;
   logic [3:0] req_type_i = '0, req_type_j = '0;
   logic signed [31:0] req_xi = '0, req_yi = '0, req_zi = '0;
   logic signed [31:0] req_xj = '0, req_yj = '0, req_zj = '0;
   logic signed [31:0] req_table_value = '0;
   logic req_last_partner = 0, req_exclusion = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [63:0] rsp_energy, rsp_force_x, rsp_force_y, rsp_force_z;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   switched_vdw_pair_accumulator DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [31:0] cuton_q = 0, cutoff_q = 0, box_q = 0;
   logic [31:0] dist_scale[256], energy_scale[256], force_scale[256];
   bit loaded_d[256], loaded_e[256], loaded_f[256], entry_ok[256];
   logic [7:0] ok_entries[$];
   logic signed [63:0] sum_e = 0, sum_x = 0, sum_y = 0, sum_z = 0;

   atom_sums_type pending_sums[$];
   stim_row_type  stim_table[$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 0, stall_pct = 0;
   logic hold_req = 0, hold_done = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // long receiver hold-off, requested once by the stimulus
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_left <= 3000;
         hold_done <= 1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   function automatic logic signed [63:0] cap_sign(input logic [127:0] m, input bit neg);
      if (m > {64'b0, SMAX}) m = {64'b0, SMAX};
      return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
   endfunction

   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic [63:0] ma, mb;
      logic [127:0] p;
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = b[63] ? 64'(-b) : 64'(b);
      p = ({64'b0, ma} * {64'b0, mb}) >> 32;
      return cap_sign(p, a[63] ^ b[63]);
   endfunction

   function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic [63:0] ma, mb;
      logic [127:0] q;
      if (b == 0) begin
         if (a == 0) return 0;
         return a[63] ? -$signed(SMAX) : $signed(SMAX);
      end
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = b[63] ? 64'(-b) : 64'(b);
      q = {32'b0, ma, 32'b0} / {64'b0, mb};
      return cap_sign(q, a[63] ^ b[63]);
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? $signed(SMIN) : $signed(SMAX);
      return $signed(s[63:0]);
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? $signed(SMIN) : $signed(SMAX);
      return $signed(s[63:0]);
   endfunction

   function automatic logic signed [63:0] word_to_q32(input logic [31:0] w);
      return $signed({{16{w[31]}}, w, 16'h0});
   endfunction

   // wrapped separation, squared distance and whether the pair contributes
   task automatic pair_geom(input pair_req_type r, output logic signed [63:0] dv[3],
                            output logic [63:0] r2, output bit live);
      logic signed [31:0] pi[3], pj[3];
      logic signed [63:0] d, bx;
      logic [63:0] m, c2;
      logic [64:0] s;
      bit far;
      pi = '{r.xi, r.yi, r.zi};
      pj = '{r.xj, r.yj, r.zj};
      bx = $signed({32'b0, box_q});
      r2 = 0;
      far = 0;
      for (int k = 0; k < 3; k++) begin
         d = $signed({{32{pi[k][31]}}, pi[k]}) - $signed({{32{pj[k][31]}}, pj[k]});
         if (2 * d < -bx) d = d + bx;
         if (2 * d > bx) d = d - bx;
         dv[k] = d;
         m = d[63] ? 64'(-d) : 64'(d);
         if (m >= 64'h1_0000_0000) begin
            far = 1;
         end else begin
            s = {1'b0, r2} + {1'b0, m * m};
            r2 = s[64] ? '1 : s[63:0];
         end
      end
      c2 = {32'b0, cutoff_q} * {32'b0, cutoff_q};
      live = !far && r2 != 0 && r2 != '1 && r2 < c2;
   endtask

   task automatic predict_step(input pair_req_type r, output atom_sums_type res,
                               output bit emits);
      logic [7:0] ix;
      logic signed [63:0] dv[3];
      logic [63:0] r2, c2, o2;
      bit live;
      logic signed [63:0] rs, gs, fgs, r2s, c2s, o2s, inv2, inv6, em1, base, tmp, dtmp, en;
      logic signed [63:0] diffc, dd, tmp1, poly, tmp2, t1, inner, t2, fq[3];
      emits = 0;
      res = '{0, 0, 0, 0};
      ix = {r.ti, r.tj};
      if (r.act != svdw_pkg::ACT_PAIR) begin
         case (r.act)
            svdw_pkg::ACT_LOAD_DIST: begin dist_scale[ix] = r.tv;   loaded_d[ix] = 1; end
            svdw_pkg::ACT_LOAD_EN:   begin energy_scale[ix] = r.tv; loaded_e[ix] = 1; end
            default:                 begin force_scale[ix] = r.tv;  loaded_f[ix] = 1; end
         endcase
         if (!entry_ok[ix] && loaded_d[ix] && loaded_e[ix] && loaded_f[ix]) begin
            entry_ok[ix] = 1;
            ok_entries.push_back(ix);
         end
         return;
      end
      pair_geom(r, dv, r2, live);
      if (live) begin
         c2 = {32'b0, cutoff_q} * {32'b0, cutoff_q};
         o2 = {32'b0, cuton_q} * {32'b0, cuton_q};
         rs = word_to_q32(dist_scale[ix]);
         gs = word_to_q32(energy_scale[ix]);
         fgs = word_to_q32(force_scale[ix]);
         r2s = r2[63] ? $signed(SMAX) : $signed(r2);
         c2s = c2[63] ? $signed(SMAX) : $signed(c2);
         o2s = o2[63] ? $signed(SMAX) : $signed(o2);
         inv2 = fx_div(Q1, fx_mul(r2s, rs));
         inv6 = fx_mul(fx_mul(inv2, inv2), inv2);
         em1 = sat_sub(inv6, Q1);
         base = fx_mul(inv6, em1);
         if (o2 < r2) begin
            // switching region
            diffc = sat_sub(c2s, r2s);
            dd = sat_sub(c2s, o2s);
            tmp1 = fx_div(diffc, fx_mul(fx_mul(dd, dd), dd));
            poly = sat_add(sat_sub(c2s, fx_mul(o2s, 3 * Q1)), fx_mul(r2s, 2 * Q1));
            tmp2 = fx_mul(fx_mul(tmp1, diffc), poly);
            t1 = fx_mul(fx_mul(fx_mul(base, 12 * Q1), sat_sub(o2s, r2s)), tmp1);
            inner = sat_add(inv6, fx_mul(em1, tmp2));
            t2 = fx_div(fx_mul(fx_mul(fx_mul(inv6, 6 * Q1), inner), tmp2), r2s);
            tmp = fx_mul(base, tmp2);
            dtmp = sat_sub(t1, t2);
         end else begin
            tmp = base;
            dtmp = fx_mul(fx_mul(inv2, inv6), sat_sub(fx_mul(inv6, 2 * Q1), Q1));
         end
         dtmp = fx_mul(dtmp, fgs);
         en = fx_mul(gs, tmp);
         for (int k = 0; k < 3; k++) fq[k] = fx_mul(dv[k] <<< 16, dtmp);
         if (r.excl) begin
            sum_e = sat_sub(sum_e, en);
            sum_x = sat_add(sum_x, fq[0]);
            sum_y = sat_add(sum_y, fq[1]);
            sum_z = sat_add(sum_z, fq[2]);
         end else begin
            sum_e = sat_add(sum_e, en);
            sum_x = sat_sub(sum_x, fq[0]);
            sum_y = sat_sub(sum_y, fq[1]);
            sum_z = sat_sub(sum_z, fq[2]);
         end
      end
      if (r.last) begin
         res = '{sum_e, sum_x, sum_y, sum_z};
         sum_e = 0;
         sum_x = 0;
         sum_y = 0;
         sum_z = 0;
         emits = 1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
      errors++;
   endtask

   // result side: random stall and checking
   always @(posedge clock) begin
      atom_sums_type w;
      rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            report_mismatch("unexpected result energy", 0, rsp_energy);
         end else begin
            w = pending_sums.pop_front();
            if (rsp_energy !== w.e)   report_mismatch("energy", w.e, rsp_energy);
            if (rsp_force_x !== w.fx) report_mismatch("force_x", w.fx, rsp_force_x);
            if (rsp_force_y !== w.fy) report_mismatch("force_y", w.fy, rsp_force_y);
            if (rsp_force_z !== w.fz) report_mismatch("force_z", w.fz, rsp_force_z);
         end
      end
   end

   task automatic send_req(input pair_req_type r, input bit lit);
      atom_sums_type res;
      bit emits;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1;
      req_action <= r.act;
      req_type_i <= r.ti;
      req_type_j <= r.tj;
      req_xi <= r.xi;
      req_yi <= r.yi;
      req_zi <= r.zi;
      req_xj <= r.xj;
      req_yj <= r.yj;
      req_zj <= r.zj;
      req_table_value <= r.tv;
      req_last_partner <= r.last;
      req_exclusion <= r.excl;
      do @(posedge clock); while (req_stall);
      predict_step(r, res, emits);
      if (emits) pending_sums.push_back(lit ? '{0, 0, 0, 0} : res);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [31:0] o, input logic [31:0] c, input logic [31:0] b);
      logic [31:0] vals[3];
      logic [1:0] idx[3];
      wait_drained();
      vals = '{o, c, b};
      idx = '{svdw_pkg::CSR_SWITCH_START, svdw_pkg::CSR_CUT_DISTANCE, svdw_pkg::CSR_BOX_LENGTH};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1;
         csr_index <= idx[k];
         csr_wdata <= vals[k];
         do @(posedge clock); while (!csr_ready);
         case (idx[k])
            svdw_pkg::CSR_SWITCH_START: cuton_q = vals[k];
            svdw_pkg::CSR_CUT_DISTANCE: cutoff_q = vals[k];
            default:                    box_q = vals[k];
         endcase
      end
      csr_valid <= 0;
   endtask

   task automatic add_pair(input logic [3:0] ti, input logic [3:0] tj,
                           input logic signed [31:0] xi, input logic signed [31:0] yi,
                           input logic signed [31:0] zi, input logic signed [31:0] xj,
                           input logic signed [31:0] yj, input logic signed [31:0] zj,
                           input logic last, input logic excl, input bit lit);
      stim_row_type s;
      s = '{0, 0, 0, 0, '{svdw_pkg::ACT_PAIR, ti, tj, xi, yi, zi, xj, yj, zj, 0, last, excl}, lit};
      stim_table.push_back(s);
   endtask

   task automatic add_load(input logic [1:0] act, input logic [3:0] ti, input logic [3:0] tj,
                           input logic signed [31:0] v);
      stim_row_type s;
      s = '{0, 0, 0, 0, '{act, ti, tj, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, v, 1, 1}, 0};
      stim_table.push_back(s);
   endtask

   function automatic logic [31:0] pick_scale(input logic [1:0] act);
      if ($urandom_range(0, 9) == 0) return $urandom;
      if (act == svdw_pkg::ACT_LOAD_DIST) return $urandom_range(32'h4000, 32'h40000);
      return $urandom_range(0, 32'h20000) - 32'h10000;
   endfunction

   // contributing pairs that would read an entry not fully loaded are moved onto a loaded one
   task automatic fix_types(inout pair_req_type r);
      logic signed [63:0] dv[3];
      logic [63:0] r2;
      bit live;
      logic [7:0] k;
      pair_geom(r, dv, r2, live);
      if (r.act == svdw_pkg::ACT_PAIR && live && !entry_ok[{r.ti, r.tj}]) begin
         k = ok_entries[$urandom_range(0, ok_entries.size() - 1)];
         r.ti = k[7:4];
         r.tj = k[3:0];
      end
   endtask

   logic [31:0] cfg_o[5] = '{32'h3_0000, 32'h0, 32'hFFFF_FFFF, 32'h2_0000, 32'h5_0000};
   logic [31:0] cfg_c[5] = '{32'h6_0000, 32'h4_0000, 32'hFFFF_FFFF, 32'h2_8000, 32'h5_0000};
   logic [31:0] cfg_b[5] = '{32'hA_0000, 32'h0, 32'hFFFF_FFFF, 32'h7_0000, 32'hC_0000};
   int mode_idle[4] = '{0, 87, 0, 10};
   int mode_stall[4] = '{0, 0, 87, 10};

   initial begin
      pair_req_type r;
      stim_row_type s;
      int sent, nparts, span;
      logic signed [31:0] ox, oy, oz;
      for (int k = 0; k < 256; k++) begin
         dist_scale[k] = 0;
         energy_scale[k] = 0;
         force_scale[k] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // registers at reset: cutoff zero, every pair skipped
      add_pair(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 1);
      add_pair(15, 15, 32'h1_0000, 0, 0, 0, 0, 0, 0, 1, 0);
      add_pair(15, 15, 32'h1_0000, 0, 0, 0, 0, 0, 1, 0, 1);
      // zero distance scale and extreme words on entry 15,15
      add_load(svdw_pkg::ACT_LOAD_DIST, 15, 15, 32'h0);
      add_load(svdw_pkg::ACT_LOAD_EN, 15, 15, 32'h7FFF_FFFF);
      add_load(svdw_pkg::ACT_LOAD_FRC, 15, 15, 32'h8000_0000);
      add_load(svdw_pkg::ACT_LOAD_DIST, 0, 0, 32'h1_0000);
      add_load(svdw_pkg::ACT_LOAD_EN, 0, 0, 32'h1_0000);
      add_load(svdw_pkg::ACT_LOAD_FRC, 0, 0, 32'h1_0000);
      add_load(svdw_pkg::ACT_LOAD_DIST, 0, 15, 32'h8000);
      add_load(svdw_pkg::ACT_LOAD_EN, 0, 15, 32'hFFFF_0000);
      add_load(svdw_pkg::ACT_LOAD_FRC, 0, 15, 32'h2_0000);
      add_load(svdw_pkg::ACT_LOAD_DIST, 15, 0, 32'h2_0000);
      add_load(svdw_pkg::ACT_LOAD_EN, 15, 0, 32'h4000);
      add_load(svdw_pkg::ACT_LOAD_FRC, 15, 0, 32'h1_0000);
      s = '{1, 32'h3_0000, 32'h6_0000, 32'hA_0000, r, 0};
      stim_table.push_back(s);
      add_pair(0, 0, 0, 0, 0, 32'h1_8000, 0, 0, 1, 0, 0);           // inside cuton
      add_pair(0, 15, 0, 0, 0, 32'h4_0000, 0, 0, 0, 0, 0);          // switching region
      add_pair(0, 15, 0, 0, 0, 0, 32'h3_8000, 0, 1, 1, 0);          // exclusion
      add_pair(0, 0, 0, 0, 0, 32'h4_0000, 32'h4_0000, 32'h4_0000, 1, 0, 1); // beyond cutoff
      add_pair(0, 0, 32'h2_0000, 32'h2_0000, 32'h2_0000,
               32'h2_0000, 32'h2_0000, 32'h2_0000, 1, 0, 1);        // zero distance
      add_pair(15, 0, 32'h4_8000, 0, 0, 32'hFFFB_8000, 0, 0, 1, 0, 0); // wraps to -1.0
      add_pair(15, 15, 0, 32'h1_0000, 0, 0, 0, 0, 1, 0, 0);         // zero distance scale
      add_pair(15, 15, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1, 0, 1); // huge separation

      foreach (stim_table[i]) begin
         if (stim_table[i].is_cfg) write_cfg(stim_table[i].o, stim_table[i].c, stim_table[i].b);
         else send_req(stim_table[i].r, stim_table[i].lit);
      end

      for (int seg = 0; seg < 8; seg++) begin
         write_cfg(cfg_o[seg % 5], cfg_c[seg % 5], cfg_b[seg % 5]);
         idle_pct = mode_idle[seg % 4];
         stall_pct = mode_stall[seg % 4];
         if (seg == 2) hold_req <= 1;
         span = (cutoff_q == 0 || cutoff_q > 32'h10_0000) ? 32'hA_0000
                                                          : cutoff_q + cutoff_q / 4;
         sent = 0;
         while (sent < 128) begin
            if ($urandom_range(0, 99) < 8) begin
               r.act = 2'($urandom_range(1, 3));
               r.ti = 4'($urandom);
               r.tj = 4'($urandom);
               {r.xi, r.yi, r.zi, r.xj, r.yj, r.zj} = {6{$urandom}};
               r.tv = pick_scale(r.act);
               r.last = 1'($urandom);
               r.excl = 1'($urandom);
               send_req(r, 0);
               sent++;
            end else if ($urandom_range(0, 99) < 4) begin
               // noise: every field random
               r = '{2'($urandom), 4'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom)};
               fix_types(r);
               send_req(r, 0);
               sent++;
            end else begin
               // one owning atom and its partners
               ox = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
               oy = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
               oz = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
               r.act = svdw_pkg::ACT_PAIR;
               r.ti = 4'($urandom);
               nparts = $urandom_range(1, 6);
               for (int p = 0; p < nparts; p++) begin
                  r.tj = 4'($urandom);
                  r.xi = ox;
                  r.yi = oy;
                  r.zi = oz;
                  case ($urandom_range(0, 19))
                     0: {r.xj, r.yj, r.zj} = {ox, oy, oz};
                     1: {r.xj, r.yj, r.zj} = {$urandom, $urandom, $urandom};
                     default: begin
                        r.xj = ox + $signed($urandom_range(0, 2 * span) - span);
                        r.yj = oy + $signed($urandom_range(0, 2 * span) - span) / 2;
                        r.zj = oz + $signed($urandom_range(0, 2 * span) - span) / 2;
                     end
                  endcase
                  r.tv = $urandom;
                  r.last = (p == nparts - 1);
                  r.excl = ($urandom_range(0, 99) < 15);
                  fix_types(r);
                  send_req(r, 0);
                  sent++;
               end
            end
         end
      end

      wait_drained();
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
